// ----- hdl/ush_pkg.sv -----
// ----------------------------------------------------------------------------
// ush_pkg
// Shared types, constants and helper functions for the UTF-8 sanitiser with
// hex escape.
// ----------------------------------------------------------------------------
package ush_pkg;

    localparam logic [7:0] C_ASCII_MAX  = 8'h7F;
    localparam logic [7:0] C_MASK_2     = 8'hE0;
    localparam logic [7:0] C_LEAD_2     = 8'hC0;
    localparam logic [7:0] C_MASK_3     = 8'hF0;
    localparam logic [7:0] C_LEAD_3     = 8'hE0;
    localparam logic [7:0] C_MASK_4     = 8'hF8;
    localparam logic [7:0] C_LEAD_4     = 8'hF0;
    localparam logic [7:0] C_MASK_CONT  = 8'hC0;
    localparam logic [7:0] C_CONT       = 8'h80;
    localparam logic [7:0] C_BACKSLASH  = 8'h5C;
    localparam logic [7:0] C_LETTER_X   = 8'h78;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAW,
        ST_BSL,
        ST_X,
        ST_HI,
        ST_LO
    } t_state;

    typedef enum logic [2:0] {
        SEL_RAW,
        SEL_BSL,
        SEL_X,
        SEL_HI,
        SEL_LO
    } t_char_sel;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_RAW,
        KIND_ESC
    } t_kind;

    typedef struct packed {
        logic      load;
        logic      advance;
        t_char_sel sel;
    } t_cmd;

    typedef struct packed {
        logic plan_any;   // accepted byte would give at least one character
        logic plan_esc0;  // first item of that plan is escaped
        logic more;       // another item follows the current one
        logic nxt_esc;    // next item is escaped
        logic last;       // current item list closes the stream
    } t_status;

    // Sequence length from a lead byte, zero when not a lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if ((b & C_MASK_2) == C_LEAD_2)      len = 3'd2;
        else if ((b & C_MASK_3) == C_LEAD_3) len = 3'd3;
        else if ((b & C_MASK_4) == C_LEAD_4) len = 3'd4;
        return len;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] d;
        if (v < 4'd10) d = 8'h30 + {4'h0, v};
        else           d = 8'h57 + {4'h0, v};
        return d;
    endfunction

endpackage

// ----- hdl/ush_datapath.sv -----
// ----------------------------------------------------------------------------
// ush_datapath
// Sequence tracking state, the item list of the current transfer and the
// output character mux.
// ----------------------------------------------------------------------------
module ush_datapath import ush_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output t_status    o_status,
    output logic [7:0] o_out_char
);

    // pending sequence
    logic [7:0] r_held [3];
    logic [1:0] r_hcnt;
    logic [2:0] r_need;

    // item list for the transfer being emitted
    logic [7:0] r_item [4];
    logic       r_esc  [4];
    logic [2:0] r_n;
    logic [1:0] r_idx;
    logic       r_last;

    logic       w_cont, w_pend, w_complete, w_extend, w_broken, w_ascii;
    logic [2:0] w_len;
    logic [1:0] w_held_n;
    logic       w_held_esc;
    t_kind      w_bkind;
    logic [2:0] w_plan_n;
    logic [7:0] w_cur;

    assign w_cont     = (i_in_byte & C_MASK_CONT) == C_CONT;
    assign w_pend     = r_hcnt != 2'd0;
    assign w_complete = w_pend && w_cont && (({1'b0, r_hcnt} + 3'd1) >= r_need);
    assign w_extend   = w_pend && w_cont && !w_complete;
    assign w_broken   = w_pend && !w_cont;
    assign w_ascii    = i_in_byte <= C_ASCII_MAX;
    assign w_len      = lead_length(i_in_byte);

    always_comb begin
        w_held_n   = 2'd0;
        w_held_esc = 1'b1;
        w_bkind    = KIND_NONE;
        if (w_complete) begin
            w_held_n   = r_hcnt;
            w_held_esc = 1'b0;
            w_bkind    = KIND_RAW;
        end else if (w_extend) begin
            // end of stream inside a sequence: everything gets escaped
            if (i_in_last) begin
                w_held_n = r_hcnt;
                w_bkind  = KIND_ESC;
            end
        end else begin
            if (w_broken) w_held_n = r_hcnt;
            if (w_ascii)              w_bkind = KIND_RAW;
            else if (w_len != 3'd0)   w_bkind = i_in_last ? KIND_ESC : KIND_NONE;
            else                      w_bkind = KIND_ESC;
        end
    end

    assign w_plan_n = {1'b0, w_held_n} + {2'b00, w_bkind != KIND_NONE};

    assign o_status.plan_any  = w_plan_n != 3'd0;
    assign o_status.plan_esc0 = (w_held_n != 2'd0) ? w_held_esc : (w_bkind == KIND_ESC);
    assign o_status.more      = ({1'b0, r_idx} + 3'd1) < r_n;
    assign o_status.nxt_esc   = r_esc[r_idx + 2'd1];
    assign o_status.last      = r_last;

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt <= 2'd0;
            r_need <= 3'd0;
        end else if (i_cmd.load) begin
            if (w_complete) begin
                r_hcnt <= 2'd0;
                r_need <= 3'd0;
            end else if (w_extend) begin
                if (i_in_last) begin
                    r_hcnt <= 2'd0;
                    r_need <= 3'd0;
                end else begin
                    r_hcnt <= r_hcnt + 2'd1;
                end
            end else if (!w_ascii && w_len != 3'd0 && !i_in_last) begin
                r_hcnt <= 2'd1;
                r_need <= w_len;
            end else begin
                r_hcnt <= 2'd0;
                r_need <= 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // extension only happens with one or two bytes held
            if (w_extend && !i_in_last && r_hcnt != 2'd3) begin
                r_held[r_hcnt] <= i_in_byte;
            end else if (!w_pend || w_broken) begin
                r_held[0] <= i_in_byte;
            end
        end
    end

    // item list: held bytes first, then the new byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_item[k] <= (2'(k) < w_held_n) ? r_held[k] : i_in_byte;
                r_esc[k]  <= (2'(k) < w_held_n) ? w_held_esc : (w_bkind == KIND_ESC);
            end
            r_item[3] <= i_in_byte;
            r_esc[3]  <= w_bkind == KIND_ESC;
            r_last    <= i_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= 3'd0;
            r_idx <= 2'd0;
        end else if (i_cmd.load) begin
            r_n   <= w_plan_n;
            r_idx <= 2'd0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    assign w_cur = r_item[r_idx];

    always_comb begin
        unique case (i_cmd.sel)
            SEL_RAW: o_out_char = w_cur;
            SEL_BSL: o_out_char = C_BACKSLASH;
            SEL_X:   o_out_char = C_LETTER_X;
            SEL_HI:  o_out_char = hex_digit(w_cur[7:4]);
            SEL_LO:  o_out_char = hex_digit(w_cur[3:0]);
            default: o_out_char = w_cur;
        endcase
    end

    a_idle_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hcnt == 2'd0) |-> (r_need == 3'd0))
        else $error("length set with no sequence pending");

    a_held_below_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hcnt != 2'd0) |-> ({1'b0, r_hcnt} < r_need))
        else $error("held bytes reached sequence length");

    a_item_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= 3'd4)
        else $error("item list overflow");

endmodule

// ----- hdl/ush_ctrl.sv -----
// ----------------------------------------------------------------------------
// ush_ctrl
// Character sequencer: walks the item list, one output character per
// transfer, four characters for each escaped item.
// ----------------------------------------------------------------------------
module ush_ctrl import ush_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output logic    o_run_last,
    output logic    o_stream_last,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    t_state w_plan_state;
    logic   w_final, w_accept, w_item_end;

    assign w_item_end   = (r_state == ST_RAW) || (r_state == ST_LO);
    assign w_final      = w_item_end && !i_status.more;
    assign o_in_ready   = (r_state == ST_IDLE) || (w_final && i_out_ready);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_plan_state = !i_status.plan_any ? ST_IDLE :
                          (i_status.plan_esc0 ? ST_BSL : ST_RAW);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = w_plan_state;
            end
            ST_RAW, ST_LO: begin
                if (i_out_ready) begin
                    if (i_status.more)  n_state = i_status.nxt_esc ? ST_BSL : ST_RAW;
                    else if (w_accept)  n_state = w_plan_state;
                    else                n_state = ST_IDLE;
                end
            end
            ST_BSL: begin
                if (i_out_ready) n_state = ST_X;
            end
            ST_X: begin
                if (i_out_ready) n_state = ST_HI;
            end
            ST_HI: begin
                if (i_out_ready) n_state = ST_LO;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.load    = w_accept;
        o_cmd.advance = w_item_end && i_out_ready && i_status.more;
        o_out_valid   = r_state != ST_IDLE;
        o_run_last    = w_final;
        o_stream_last = w_final && i_status.last;
        unique case (r_state)
            ST_BSL:  o_cmd.sel = SEL_BSL;
            ST_X:    o_cmd.sel = SEL_X;
            ST_HI:   o_cmd.sel = SEL_HI;
            ST_LO:   o_cmd.sel = SEL_LO;
            default: o_cmd.sel = SEL_RAW;
        endcase
    end

    a_escape_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BSL && i_out_ready) |=> (r_state == ST_X))
        else $error("escape sequence out of order");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(r_state))
        else $error("sequencer moved while output stalled");

    a_load_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_cmd.advance)
        else $error("load and advance in the same cycle");

endmodule

// ----- hdl/utf8_sanitizer_hex_escape.sv -----
// ----------------------------------------------------------------------------
// utf8_sanitizer_hex_escape
// Streaming UTF-8 sanitiser: valid sequences pass, bad bytes become \xhh.
// ----------------------------------------------------------------------------
// One output character leaves per clock cycle while the output is ready; the
// block is limited by its single character sequencer. An input byte causes
// one character for a plain byte and four per escaped byte, up to 16 in all,
// and none when it only extends a pending sequence. The next byte is taken
// in the cycle the last character of the previous one is transferred, so
// clean ASCII text runs at one byte per cycle while the output is ready.
module utf8_sanitizer_hex_escape import ush_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_run_last,
    output logic       o_stream_last
);

    t_cmd    w_cmd;
    t_status w_status;

    ush_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_run_last    (o_run_last),
        .o_stream_last (o_stream_last),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    ush_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_status   (w_status),
        .o_out_char (o_out_char)
    );

endmodule
